// ===== hw/rtl/fsubm_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fsubm_pkg: shared types and constants of the first substring match block
// Sizes of the pattern row and text counter, operation codes, cell controls.
// ---------------------------------------------------------------------------
package fsubm_pkg;

  localparam int MAX_PATTERN = 128;
  localparam int MAX_TEXT    = 65536;

  // pattern length counts 0..MAX_PATTERN
  localparam int LEN_W   = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  // text position counts 0..MAX_TEXT
  localparam int POS_W   = $clog2(MAX_TEXT + 1);
  localparam int INDEX_W = 16;
  localparam int CALC_A  = (POS_W > LEN_W) ? POS_W : LEN_W;
  localparam int CALC_W  = (CALC_A > INDEX_W) ? CALC_A : INDEX_W;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2,
    OP_END    = 2'd3
  } op_t;

  // controls broadcast to every cell of the row
  typedef struct packed {
    logic       restart;   // drop all partial matches
    logic       shift;     // a text byte steps through the row
    logic       load;      // a pattern byte is written to the selected cell
    logic [7:0] data;      // text or pattern byte
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== hw/rtl/fsubm_cell.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fsubm_cell: one pattern position of the shift-and row
// Holds a pattern byte and the partial match bit for the prefix ending here.
// ---------------------------------------------------------------------------
module fsubm_cell
  import fsubm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       sel,         // this cell is the next free pattern slot
  input  wire logic       prev_match,  // partial match of the cell below
  output logic            match,
  output logic            match_next
);

  logic [7:0] pat;

  // prefix up to here completes with the current byte
  assign match_next = prev_match && (pat == ctrl.data);

  always_ff @(posedge clk) begin
    if (ctrl.load && sel) begin
      pat <= ctrl.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      match <= 1'b0;
    end else if (ctrl.shift) begin
      match <= match_next;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fsubm_chain.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// fsubm_chain: row of pattern cells
// Each cell passes its match bit up the row; the tail picks the last prefix.
// ---------------------------------------------------------------------------
module fsubm_chain
  import fsubm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [LEN_W-1:0] len,
  output logic                  hit       // full pattern completes on this byte
);

  logic [MAX_PATTERN-1:0] match;
  logic [MAX_PATTERN-1:0] match_next;
  logic [MAX_PATTERN-1:0] prev;
  logic [LEN_W-1:0]       last;
  logic [IDX_W-1:0]       wr_idx;
  logic [IDX_W-1:0]       last_idx;

  assign wr_idx   = IDX_W'(len);
  assign last     = len - LEN_W'(1);
  assign last_idx = IDX_W'(last);

  assign prev[0] = 1'b1;
  if (MAX_PATTERN > 1) begin : g_prev
    assign prev[MAX_PATTERN-1:1] = match[MAX_PATTERN-2:0];
  end

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    fsubm_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .sel        (wr_idx == IDX_W'(j)),
      .prev_match (prev[j]),
      .match      (match[j]),
      .match_next (match_next[j])
    );
  end

  assign hit = (len != '0) && match_next[last_idx];

endmodule
`default_nettype wire

// ===== hw/rtl/first_substring_match.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// first_substring_match: first occurrence of a pattern in a byte stream
// Shift-and matcher built as a row of pattern cells.
// ---------------------------------------------------------------------------
// Usage: one input channel (s_*) carries transactions with an operation in
// s_tuser and a byte in s_tdata: clear pattern, append pattern byte, text
// byte, end of text. Up to MAX_PATTERN pattern bytes are kept, further ones
// dropped. Clear and append restart the text scan. Every text byte moves the
// partial-match bits one cell up the row, so one transaction is taken per
// cycle while s_tready is high; the row checks the byte in all cells at once.
// End of text yields one result transaction on m_*: found in m_tuser,
// start index of the first occurrence in m_tdata (0 when not found). An
// empty pattern is found at 0. Positions at or past MAX_TEXT are ignored.
// The result appears in the cycle after the end-of-text transaction, from an
// output register. Input is taken whenever that register is empty or is being
// emptied, so a stalled receiver holds back the input after one result waits.
// Reset clears the pattern length, scan state and output valid; the pattern
// bytes themselves are not cleared and need no clearing pass.
// ---------------------------------------------------------------------------
module first_substring_match
  import fsubm_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [7:0]          s_tdata,   // [7:0] data_byte
  input  wire logic [1:0]          s_tuser,   // [1:0] operation
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [INDEX_W-1:0]       m_tdata,   // [15:0] match_index
  output logic                     m_tuser    // [0] found
);

  cell_ctrl_t         ctrl;
  op_t                op;
  logic               accept;
  logic               hit;
  logic [LEN_W-1:0]   len;
  logic [POS_W-1:0]   tp;
  logic               found;
  logic [INDEX_W-1:0] found_pos;
  logic [CALC_W-1:0]  start;

  assign op       = op_t'(s_tuser);
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  assign ctrl.restart = accept && (op != OP_TEXT);
  assign ctrl.shift   = accept && (op == OP_TEXT) && (tp < POS_W'(MAX_TEXT));
  assign ctrl.load    = accept && (op == OP_APPEND) && (len < LEN_W'(MAX_PATTERN));
  assign ctrl.data    = s_tdata;

  fsubm_chain u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .len  (len),
    .hit  (hit)
  );

  // start of a match ending at the current position
  assign start = CALC_W'(tp) + CALC_W'(1) - CALC_W'(len);

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (accept && op == OP_CLEAR) begin
      len <= '0;
    end else if (ctrl.load) begin
      len <= len + LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      tp        <= '0;
      found     <= 1'b0;
      found_pos <= '0;
    end else if (ctrl.shift) begin
      tp <= tp + POS_W'(1);
      if (hit && !found) begin
        found     <= 1'b1;
        found_pos <= start[INDEX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept && op == OP_END) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && op == OP_END) begin
      m_tuser <= (len == '0) || found;
      m_tdata <= (len != '0 && found) ? found_pos : '0;
    end
  end

`ifndef SYNTHESIS
  a_found_needs_pattern: assert property (@(posedge clk) disable iff (rst)
    found |-> (len != '0))
    else $error("match latched with empty pattern");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    tp <= POS_W'(MAX_TEXT))
    else $error("text position past saturation");

  a_result_from_end: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(accept && op == OP_END))
    else $error("result without end of text");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output register");
`endif

endmodule
`default_nettype wire

// ===== verif/first_substring_match_tb.sv =====
// ---------------------------------------------------------------------------
// first_substring_match_tb: self-checking bench for the first substring match
// Pattern and text transactions are queued and sent through the s_* stream.
// A local shift-and model predicts each end-of-text result. Results on m_*
// are checked against it in order, under random stalls on both sides.
// ---------------------------------------------------------------------------
module first_substring_match_tb;
  import fsubm_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int RX_HOLD_AFTER = 20;

  typedef struct {
    op_t        op;
    logic [7:0] data;
  } scan_item_t;

  typedef struct {
    logic        found;
    logic [15:0] index;
  } match_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic [1:0]  s_tuser = OP_CLEAR;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;

  scan_item_t    pending_items[$];
  match_result_t expected_matches[$];

  int tx_idle_pct = 29;
  int rx_idle_pct = 54;
  int pushed_total = 0;
  int accepted_total = 0;
  int mismatch_cnt = 0;
  int stall_cycles = 0;
  int rx_seen = 0;
  int rx_hold_left = 0;
  logic rx_hold_done = 1'b0;

  // local copy of the matcher state
  logic [7:0]             pat_bytes [MAX_PATTERN];
  int                     pat_len = 0;
  logic [MAX_PATTERN-1:0] prefix_hits = '0;
  int unsigned            txt_pos = 0;
  logic                   hit_flag = 1'b0;
  int unsigned            hit_pos = 0;

  first_substring_match uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  task automatic restart_scan();
    prefix_hits = '0;
    txt_pos = 0;
    hit_flag = 1'b0;
    hit_pos = 0;
  endtask

  task automatic predict_match(input op_t op, input logic [7:0] b);
    logic [MAX_PATTERN-1:0] nxt_hits;
    match_result_t          res;
    case (op)
      OP_CLEAR: begin
        pat_len = 0;
        restart_scan();
      end
      OP_APPEND: begin
        if (pat_len < MAX_PATTERN) begin
          pat_bytes[pat_len] = b;
          pat_len++;
        end
        restart_scan();
      end
      OP_TEXT: begin
        // bytes past the end of the text window are dropped
        if (txt_pos < MAX_TEXT) begin
          if (pat_len > 0) begin
            nxt_hits = prefix_hits;
            nxt_hits[0] = (pat_bytes[0] == b);
            for (int j = 1; j < pat_len; j++)
              nxt_hits[j] = prefix_hits[j-1] && (pat_bytes[j] == b);
            prefix_hits = nxt_hits;
            if (nxt_hits[pat_len-1] && !hit_flag) begin
              hit_flag = 1'b1;
              hit_pos = txt_pos + 1 - pat_len;
            end
          end
          txt_pos++;
        end
      end
      default: begin
        if (pat_len == 0) begin
          res.found = 1'b1;
          res.index = 16'd0;
        end else if (hit_flag) begin
          res.found = 1'b1;
          res.index = hit_pos[15:0];
        end else begin
          res.found = 1'b0;
          res.index = 16'd0;
        end
        expected_matches.push_back(res);
        restart_scan();
      end
    endcase
  endtask

  task automatic push_item(input op_t op, input logic [7:0] b);
    scan_item_t it;
    it.op = op;
    it.data = b;
    pending_items.push_back(it);
    pushed_total++;
  endtask

  // mostly clear/append/text/end runs over a tiny alphabet, so matches are
  // common; the rest is random noise or runs that never end
  task automatic push_random_run();
    int          r;
    int          asz;
    int          plen;
    int          tlen;
    logic [7:0]  base;
    r = $urandom_range(99);
    if (r < 8) begin
      repeat ($urandom_range(1, 6))
        push_item(op_t'($urandom_range(3)), 8'($urandom_range(255)));
    end else begin
      base = 8'($urandom_range(255));
      asz = $urandom_range(1, 3);
      if ($urandom_range(3) != 0)
        push_item(OP_CLEAR, 8'($urandom_range(255)));
      plen = ($urandom_range(9) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      repeat (plen)
        push_item(OP_APPEND, base ^ 8'($urandom_range(asz - 1)));
      tlen = $urandom_range(0, 24);
      repeat (tlen) begin
        if ($urandom_range(19) == 0)
          push_item(OP_TEXT, 8'($urandom_range(255)));
        else
          push_item(OP_TEXT, base ^ 8'($urandom_range(asz - 1)));
      end
      if ($urandom_range(9) != 0)
        push_item(OP_END, 8'($urandom_range(255)));
    end
  endtask

  // pattern overflow: only the first MAX_PATTERN bytes are kept
  task automatic push_full_pattern_run();
    logic [7:0] full_pat [MAX_PATTERN + 2];
    push_item(OP_CLEAR, 8'h00);
    for (int i = 0; i < MAX_PATTERN + 2; i++) begin
      full_pat[i] = 8'($urandom_range(255));
      push_item(OP_APPEND, full_pat[i]);
    end
    repeat (5) push_item(OP_TEXT, 8'($urandom_range(255)));
    for (int i = 0; i < MAX_PATTERN; i++)
      push_item(OP_TEXT, full_pat[i]);
    repeat (3) push_item(OP_TEXT, 8'($urandom_range(255)));
    push_item(OP_END, 8'h00);
  endtask

  task automatic wait_drained();
    while (!(accepted_total == pushed_total && expected_matches.size() == 0))
      @(posedge clk);
    @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin : driver
    scan_item_t nxt_item;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_match(op_t'(s_tuser), s_tdata);
        accepted_total++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= nxt_item.op;
          s_tdata <= nxt_item.data;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random backpressure plus one long hold to back up the input
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready)
        rx_seen <= rx_seen + 1;
      if (rx_hold_left > 0) begin
        rx_hold_left <= rx_hold_left - 1;
        m_tready <= 1'b0;
      end else if (!rx_hold_done && rx_seen >= RX_HOLD_AFTER) begin
        rx_hold_done <= 1'b1;
        rx_hold_left <= RX_HOLD_CYCLES;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    match_result_t exp_r;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_matches.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected result: found=%0b index=%0d", m_tuser, m_tdata);
      end else begin
        exp_r = expected_matches.pop_front();
        if (exp_r.found !== m_tuser || exp_r.index !== m_tdata) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                     exp_r.found, exp_r.index, m_tuser, m_tdata);
        end
      end
    end
  end

  // watchdog: no transaction on either side for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int start_cnt;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty pattern, empty and non-empty text
    push_item(OP_END, 8'h00);
    push_item(OP_TEXT, 8'h00);
    push_item(OP_TEXT, 8'hFF);
    push_item(OP_END, 8'hFF);
    // two-byte pattern, repeat matches latch the first
    push_item(OP_APPEND, 8'hAB);
    push_item(OP_APPEND, 8'hCD);
    push_item(OP_TEXT, 8'hAB);
    push_item(OP_TEXT, 8'hAB);
    push_item(OP_TEXT, 8'hCD);
    push_item(OP_TEXT, 8'hAB);
    push_item(OP_TEXT, 8'hCD);
    push_item(OP_END, 8'h00);
    // pattern longer than text
    push_item(OP_TEXT, 8'hAB);
    push_item(OP_END, 8'h00);
    // append mid-text restarts the scan
    push_item(OP_TEXT, 8'hAB);
    push_item(OP_APPEND, 8'h00);
    push_item(OP_TEXT, 8'hAB);
    push_item(OP_TEXT, 8'hCD);
    push_item(OP_TEXT, 8'h00);
    push_item(OP_END, 8'h00);
    // clear back to empty, then one-byte pattern at index 0
    push_item(OP_CLEAR, 8'hFF);
    push_item(OP_END, 8'h00);
    push_item(OP_CLEAR, 8'h00);
    push_item(OP_APPEND, 8'hFF);
    push_item(OP_TEXT, 8'hFF);
    push_item(OP_END, 8'h00);

    start_cnt = pushed_total;
    while (pushed_total - start_cnt < 400) push_random_run();
    wait_drained();

    tx_idle_pct = 54;
    rx_idle_pct = 29;
    push_full_pattern_run();
    start_cnt = pushed_total;
    while (pushed_total - start_cnt < 360) push_random_run();
    wait_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    start_cnt = pushed_total;
    while (pushed_total - start_cnt < 330) push_random_run();
    wait_drained();

    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
